[hdl/msbwt_pkg.sv]
// ----------------------------------------------------------------------------
// msbwt_pkg
// Shared types and constants for the multi-string BWT builder.
// ----------------------------------------------------------------------------
package msbwt_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF = 4096;
  localparam int unsigned MAX_STRINGS_DEF = 256;
  localparam int unsigned ALPHABET        = 256;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_LOAD_PRIOR = 3'd1,
    OP_LOAD_TEXT  = 3'd2,
    OP_BUILD      = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD     = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  symbol;
    logic [11:0] read_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  bwt_symbol;
    logic [12:0] bwt_total_length;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_ENDQ, ST_ENDW, ST_ZRD, ST_ZCHK, ST_INIT, ST_CLR,
    ST_ENT, ST_E1, ST_E2, ST_E3, ST_E4, ST_GAP, ST_G1, ST_G2, ST_INS, ST_I1,
    ST_I2, ST_PFX, ST_PFX1, ST_SRT, ST_S1, ST_S2, ST_CPY, ST_C1, ST_PASS,
    ST_DONE
  } state_t;

endpackage

[hdl/msbwt_ram.sv]
// ----------------------------------------------------------------------------
// msbwt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msbwt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/multi_string_bwt_builder.sv]
// ----------------------------------------------------------------------------
// multi_string_bwt_builder
// Builds the BWT of a string collection by column-wise insertion over a
// prior BWT; loads, builds and reads back one symbol per beat.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | operation, symbol, read_position
// out_    | out | out_valid/out_stall| bwt_symbol, bwt_total_length, status
//
// Clear and load beats are handled in ST_IDLE; a read also passes ST_READ (one RAM read).
// A build runs a sequencer over shared RAM ports: a zero scan of the prior
// BWT, then per pass a count clear of all 256 symbols, a per-string entry
// fetch, gap copy and insert, a prefix sweep and sort/copy.
// Reset clears control state only; RAM contents are undefined until written.
// in_stall is high while a build or read runs or a result waits stalled.
// ----------------------------------------------------------------------------
module multi_string_bwt_builder #(
  parameter int unsigned MAX_SYMBOLS = msbwt_pkg::MAX_SYMBOLS_DEF,
  parameter int unsigned MAX_STRINGS = msbwt_pkg::MAX_STRINGS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  msbwt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output msbwt_pkg::out_item_t out_data
);

  localparam int unsigned AW = $clog2(MAX_SYMBOLS);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned SW = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam int unsigned CW = SW + 1;
  localparam int unsigned EW = LW + SW + 8;
  localparam int unsigned NA = msbwt_pkg::ALPHABET;

  msbwt_pkg::state_t state_r, state_nxt;

  logic [LW-1:0] prior_len_r, prior_len_nxt, text_len_r, text_len_nxt;
  logic [CW-1:0] str_cnt_r, str_cnt_nxt;
  logic          cur_r, cur_nxt;
  logic          out_valid_r, out_valid_nxt;
  msbwt_pkg::out_item_t out_data_r, out_data_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [LW-1:0] len_r, len_nxt, pass_r, pass_nxt, zeros_r, zeros_nxt;
  logic [LW-1:0] sp_r, sp_nxt, dp_r, dp_nxt, pre_r, pre_nxt, gap_r, gap_nxt;
  logic [LW-1:0] stop_r, stop_nxt, e_pos_r, e_pos_nxt;
  logic [LW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] n_r, n_nxt, n0_r, n0_nxt, m_r, m_nxt, k_r, k_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic [SW-1:0] e_str_r, e_str_nxt;
  logic [7:0]    c_r, c_nxt, hold_r, hold_nxt, idx_r, idx_nxt;
  logic          cond_r, cond_nxt, tail_r, tail_nxt;

  // RAM ports
  logic          txt_we;  logic [AW-1:0] txt_wa, txt_ra; logic [7:0] txt_wd, txt_rd;
  logic          a_we, b_we; logic [AW-1:0] a_wa, b_wa; logic [7:0] a_wd, b_wd;
  logic [7:0]    a_rd, b_rd;
  logic          cw_we;   logic [AW-1:0] cw_wa; logic [7:0] cw_wd;
  logic          dw_we;   logic [AW-1:0] dw_wa; logic [7:0] dw_wd;
  logic [AW-1:0] src_ra;  logic [7:0] src_rd;
  logic          end_we;  logic [SW-1:0] end_wa, end_ra; logic [LW-1:0] end_wd, end_rd;
  logic          act_we;  logic [SW-1:0] act_wa, act_ra; logic [EW-1:0] act_wd, act_rd;
  logic          srt_we;  logic [SW-1:0] srt_wa, srt_ra; logic [EW-1:0] srt_wd, srt_rd;
  logic          sc_we;   logic [7:0] sc_wa, sc_ra; logic [LW-1:0] sc_wd, sc_rd;
  logic          cc_we;   logic [7:0] cc_wa, cc_ra; logic [CW-1:0] cc_wd, cc_rd;

  logic          in_acc;
  logic [LW:0]   fill_sum;
  logic          full;
  logic [LW-1:0] act_pos, start_v, inserted_v;
  logic [SW-1:0] act_str;
  logic [7:0]    act_sym;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != msbwt_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign fill_sum  = {1'b0, prior_len_r} + {1'b0, text_len_r};
  assign full      = fill_sum >= (LW+1)'(MAX_SYMBOLS);
  assign act_pos   = act_rd[EW-1 -: LW];
  assign act_str   = act_rd[8 +: SW];
  assign act_sym   = act_rd[7:0];
  assign src_rd    = cur_r ? b_rd : a_rd;
  assign start_v   = (e_str_r == '0) ? '0 : end_rd + LW'(1);
  assign inserted_v = (n_r == '0) ? '0 : end_rd + LW'(1);

  // Current buffer takes idle writes, the other one takes pass output
  always_comb begin
    a_we = cur_r ? dw_we : cw_we;
    a_wa = cur_r ? dw_wa : cw_wa;
    a_wd = cur_r ? dw_wd : cw_wd;
    b_we = cur_r ? cw_we : dw_we;
    b_wa = cur_r ? cw_wa : dw_wa;
    b_wd = cur_r ? cw_wd : dw_wd;
  end

  msbwt_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_text (
    .clk, .we(txt_we), .waddr(txt_wa), .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd));
  msbwt_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_bwt_a (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(src_ra), .rdata(a_rd));
  msbwt_ram #(.WIDTH(8), .DEPTH(MAX_SYMBOLS)) u_bwt_b (
    .clk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(src_ra), .rdata(b_rd));
  msbwt_ram #(.WIDTH(LW), .DEPTH(MAX_STRINGS)) u_ends (
    .clk, .we(end_we), .waddr(end_wa), .wdata(end_wd), .raddr(end_ra), .rdata(end_rd));
  msbwt_ram #(.WIDTH(EW), .DEPTH(MAX_STRINGS)) u_active (
    .clk, .we(act_we), .waddr(act_wa), .wdata(act_wd), .raddr(act_ra), .rdata(act_rd));
  msbwt_ram #(.WIDTH(EW), .DEPTH(MAX_STRINGS)) u_sorted (
    .clk, .we(srt_we), .waddr(srt_wa), .wdata(srt_wd), .raddr(srt_ra), .rdata(srt_rd));
  msbwt_ram #(.WIDTH(LW), .DEPTH(NA)) u_sym_cnt (
    .clk, .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));
  msbwt_ram #(.WIDTH(CW), .DEPTH(NA)) u_col_cnt (
    .clk, .we(cc_we), .waddr(cc_wa), .wdata(cc_wd), .raddr(cc_ra), .rdata(cc_rd));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msbwt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.operation)
            msbwt_pkg::OP_BUILD: state_nxt = msbwt_pkg::ST_ENDQ;
            msbwt_pkg::OP_READ: begin
              if (LW'(in_data.read_position) < prior_len_r &&
                  {1'b0, in_data.read_position} < 13'(MAX_SYMBOLS)) begin
                state_nxt = msbwt_pkg::ST_READ;
              end
            end
            default: state_nxt = msbwt_pkg::ST_IDLE;
          endcase
        end
      end
      msbwt_pkg::ST_READ: state_nxt = msbwt_pkg::ST_IDLE;
      msbwt_pkg::ST_ENDQ: state_nxt = msbwt_pkg::ST_ENDW;
      msbwt_pkg::ST_ENDW: state_nxt = (n_r == '0) ? msbwt_pkg::ST_DONE : msbwt_pkg::ST_ZRD;
      msbwt_pkg::ST_ZRD:  state_nxt = (sp_r < len_r) ? msbwt_pkg::ST_ZCHK : msbwt_pkg::ST_INIT;
      msbwt_pkg::ST_ZCHK: state_nxt = msbwt_pkg::ST_ZRD;
      msbwt_pkg::ST_INIT: state_nxt = (k_r < n_r) ? msbwt_pkg::ST_INIT : msbwt_pkg::ST_CLR;
      msbwt_pkg::ST_CLR:  state_nxt = (idx_r == 8'(NA - 1)) ? msbwt_pkg::ST_ENT : msbwt_pkg::ST_CLR;
      msbwt_pkg::ST_ENT:  state_nxt = (k_r < n0_r) ? msbwt_pkg::ST_E1 : msbwt_pkg::ST_GAP;
      msbwt_pkg::ST_E1:   state_nxt = msbwt_pkg::ST_E2;
      msbwt_pkg::ST_E2:   state_nxt = msbwt_pkg::ST_E3;
      msbwt_pkg::ST_E3:   state_nxt = msbwt_pkg::ST_E4;
      msbwt_pkg::ST_E4:   state_nxt = msbwt_pkg::ST_GAP;
      msbwt_pkg::ST_GAP: begin
        if ((tail_r || gap_r != '0) && sp_r < len_r) begin
          state_nxt = msbwt_pkg::ST_G1;
        end else begin
          state_nxt = tail_r ? msbwt_pkg::ST_PFX : msbwt_pkg::ST_INS;
        end
      end
      msbwt_pkg::ST_G1:   state_nxt = msbwt_pkg::ST_G2;
      msbwt_pkg::ST_G2:   state_nxt = msbwt_pkg::ST_GAP;
      msbwt_pkg::ST_INS:  state_nxt = msbwt_pkg::ST_I1;
      msbwt_pkg::ST_I1:   state_nxt = (c_r != 8'd0) ? msbwt_pkg::ST_I2 : msbwt_pkg::ST_ENT;
      msbwt_pkg::ST_I2:   state_nxt = msbwt_pkg::ST_ENT;
      msbwt_pkg::ST_PFX:  state_nxt = msbwt_pkg::ST_PFX1;
      msbwt_pkg::ST_PFX1: state_nxt = (idx_r == 8'(NA - 1)) ? msbwt_pkg::ST_SRT : msbwt_pkg::ST_PFX;
      msbwt_pkg::ST_SRT:  state_nxt = (k_r < m_r) ? msbwt_pkg::ST_S1 : msbwt_pkg::ST_CPY;
      msbwt_pkg::ST_S1:   state_nxt = msbwt_pkg::ST_S2;
      msbwt_pkg::ST_S2:   state_nxt = msbwt_pkg::ST_SRT;
      msbwt_pkg::ST_CPY:  state_nxt = (k_r < m_r) ? msbwt_pkg::ST_C1 : msbwt_pkg::ST_PASS;
      msbwt_pkg::ST_C1:   state_nxt = msbwt_pkg::ST_CPY;
      msbwt_pkg::ST_PASS: state_nxt = (m_r == '0) ? msbwt_pkg::ST_DONE : msbwt_pkg::ST_CLR;
      msbwt_pkg::ST_DONE: state_nxt = msbwt_pkg::ST_IDLE;
      default:            state_nxt = msbwt_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    prior_len_nxt = prior_len_r;  text_len_nxt = text_len_r;  str_cnt_nxt = str_cnt_r;
    cur_nxt = cur_r;              status_nxt = status_r;      len_nxt = len_r;
    pass_nxt = pass_r;            zeros_nxt = zeros_r;        sp_nxt = sp_r;
    dp_nxt = dp_r;                pre_nxt = pre_r;            gap_nxt = gap_r;
    stop_nxt = stop_r;            e_pos_nxt = e_pos_r;        acc_nxt = acc_r;
    n_nxt = n_r;                  n0_nxt = n0_r;              m_nxt = m_r;
    k_nxt = k_r;                  off_nxt = off_r;            e_str_nxt = e_str_r;
    c_nxt = c_r;                  hold_nxt = hold_r;          idx_nxt = idx_r;
    cond_nxt = cond_r;            tail_nxt = tail_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    txt_we = 1'b0; txt_wa = AW'(text_len_r); txt_wd = in_data.symbol;
    txt_ra = AW'(stop_r - LW'(1) - pass_r);
    cw_we = 1'b0; cw_wa = AW'(prior_len_r); cw_wd = in_data.symbol;
    dw_we = 1'b0; dw_wa = AW'(dp_r); dw_wd = c_r;
    src_ra = AW'(sp_r);
    end_we = 1'b0; end_wa = SW'(str_cnt_r); end_wd = text_len_r;
    end_ra = SW'(n_r - CW'(1));
    act_we = 1'b0; act_wa = SW'(k_r); act_ra = SW'(k_r);
    act_wd = {e_pos_r, e_str_r, c_r};
    srt_we = 1'b0; srt_wa = SW'(cc_rd); srt_ra = SW'(k_r);
    srt_wd = {e_pos_r + sc_rd + LW'(m_r), e_str_r, c_r};
    sc_we = 1'b0; sc_wa = idx_r; sc_wd = '0; sc_ra = idx_r;
    cc_we = 1'b0; cc_wa = idx_r; cc_wd = '0; cc_ra = idx_r;

    case (state_r)
      msbwt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.operation)
            msbwt_pkg::OP_CLEAR: begin
              prior_len_nxt = '0; text_len_nxt = '0; str_cnt_nxt = '0; cur_nxt = 1'b0;
            end
            msbwt_pkg::OP_LOAD_PRIOR: begin
              if (full) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{8'd0, 13'(prior_len_r), msbwt_pkg::STATUS_BAD};
              end else begin
                cw_we = 1'b1;
                prior_len_nxt = prior_len_r + LW'(1);
              end
            end
            msbwt_pkg::OP_LOAD_TEXT: begin
              if (full || (in_data.symbol == 8'd0 &&
                           str_cnt_r >= CW'(MAX_STRINGS))) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{8'd0, 13'(prior_len_r), msbwt_pkg::STATUS_BAD};
              end else begin
                if (in_data.symbol == 8'd0) begin
                  end_we = 1'b1;
                  str_cnt_nxt = str_cnt_r + CW'(1);
                end
                txt_we = 1'b1;
                text_len_nxt = text_len_r + LW'(1);
              end
            end
            msbwt_pkg::OP_BUILD: n_nxt = str_cnt_r;
            msbwt_pkg::OP_READ: begin
              src_ra = AW'(in_data.read_position);
              if (!(LW'(in_data.read_position) < prior_len_r &&
                    {1'b0, in_data.read_position} < 13'(MAX_SYMBOLS))) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{8'd0, 13'(prior_len_r), msbwt_pkg::STATUS_BAD};
              end
            end
            default: ;
          endcase
        end
      end
      msbwt_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{src_rd, 13'(prior_len_r), msbwt_pkg::STATUS_OK};
      end
      msbwt_pkg::ST_ENDQ: ;
      msbwt_pkg::ST_ENDW: begin
        status_nxt = (text_len_r > inserted_v) ? msbwt_pkg::STATUS_DROPPED
                                               : msbwt_pkg::STATUS_OK;
        text_len_nxt = '0; str_cnt_nxt = '0;
        len_nxt = prior_len_r; sp_nxt = '0; zeros_nxt = '0; k_nxt = '0;
      end
      msbwt_pkg::ST_ZRD: begin
        if (sp_r >= len_r) k_nxt = '0;
      end
      msbwt_pkg::ST_ZCHK: begin
        if (src_rd == 8'd0) zeros_nxt = zeros_r + LW'(1);
        sp_nxt = sp_r + LW'(1);
      end
      msbwt_pkg::ST_INIT: begin
        if (k_r < n_r) begin
          act_we = 1'b1;
          act_wd = {LW'(k_r) + zeros_r, SW'(k_r), 8'd0};
          k_nxt = k_r + CW'(1);
        end else begin
          pass_nxt = '0; n0_nxt = n_r; idx_nxt = '0;
        end
      end
      msbwt_pkg::ST_CLR: begin
        sc_we = 1'b1; cc_we = 1'b1;
        idx_nxt = idx_r + 8'd1;
        k_nxt = '0; pre_nxt = '0; sp_nxt = '0; dp_nxt = '0; m_nxt = '0; tail_nxt = 1'b0;
      end
      msbwt_pkg::ST_ENT: begin
        if (k_r >= n0_r) tail_nxt = 1'b1;
      end
      msbwt_pkg::ST_E1: begin
        e_pos_nxt = act_pos; e_str_nxt = act_str;
        gap_nxt = (act_pos >= pre_r) ? act_pos - pre_r : '0;
        end_ra = act_str;
      end
      msbwt_pkg::ST_E2: begin
        stop_nxt = end_rd;
        end_ra = e_str_r - SW'(1);
      end
      msbwt_pkg::ST_E3: begin
        cond_nxt = (stop_r >= start_v) && (pass_r < stop_r - start_v);
      end
      msbwt_pkg::ST_E4: c_nxt = cond_r ? txt_rd : 8'd0;
      msbwt_pkg::ST_GAP: begin
        if (tail_r) idx_nxt = '0;
        acc_nxt = '0; off_nxt = '0;
      end
      msbwt_pkg::ST_G1: begin
        hold_nxt = src_rd;
        dw_we = 1'b1; dw_wd = src_rd;
        dp_nxt = dp_r + LW'(1); sp_nxt = sp_r + LW'(1);
        if (gap_r != '0) gap_nxt = gap_r - LW'(1);
        sc_ra = src_rd;
      end
      msbwt_pkg::ST_G2: begin
        sc_we = 1'b1; sc_wa = hold_r; sc_wd = sc_rd + LW'(1);
      end
      msbwt_pkg::ST_INS: begin
        dw_we = 1'b1;
        dp_nxt = dp_r + LW'(1);
        pre_nxt = e_pos_r + LW'(1);
        sc_ra = c_r;
      end
      msbwt_pkg::ST_I1: begin
        e_pos_nxt = sc_rd;
        sc_we = 1'b1; sc_wa = c_r; sc_wd = sc_rd + LW'(1);
        cc_ra = c_r;
        if (c_r == 8'd0) k_nxt = k_r + CW'(1);
      end
      msbwt_pkg::ST_I2: begin
        act_we = 1'b1; act_wa = SW'(m_r);
        cc_we = 1'b1; cc_wa = c_r; cc_wd = cc_rd + CW'(1);
        m_nxt = m_r + CW'(1); k_nxt = k_r + CW'(1);
      end
      msbwt_pkg::ST_PFX: ;
      msbwt_pkg::ST_PFX1: begin
        // exclusive prefix sums, written back in place
        sc_we = 1'b1; sc_wd = acc_r;
        cc_we = 1'b1; cc_wd = off_r;
        acc_nxt = acc_r + sc_rd; off_nxt = off_r + cc_rd;
        idx_nxt = idx_r + 8'd1;
        k_nxt = '0;
      end
      msbwt_pkg::ST_SRT: begin
        if (k_r >= m_r) k_nxt = '0;
      end
      msbwt_pkg::ST_S1: begin
        e_pos_nxt = act_pos; e_str_nxt = act_str; c_nxt = act_sym;
        sc_ra = act_sym; cc_ra = act_sym;
      end
      msbwt_pkg::ST_S2: begin
        srt_we = 1'b1;
        cc_we = 1'b1; cc_wa = c_r; cc_wd = cc_rd + CW'(1);
        k_nxt = k_r + CW'(1);
      end
      msbwt_pkg::ST_CPY: ;
      msbwt_pkg::ST_C1: begin
        act_we = 1'b1; act_wd = srt_rd;
        k_nxt = k_r + CW'(1);
      end
      msbwt_pkg::ST_PASS: begin
        len_nxt = len_r + LW'(n0_r);
        cur_nxt = ~cur_r;
        n0_nxt = m_r;
        pass_nxt = pass_r + LW'(1);
        idx_nxt = '0;
      end
      msbwt_pkg::ST_DONE: begin
        prior_len_nxt = len_r;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{8'd0, 13'(len_r), status_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msbwt_pkg::ST_IDLE;
      prior_len_r <= '0;
      text_len_r  <= '0;
      str_cnt_r   <= '0;
      cur_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prior_len_r <= prior_len_nxt;
      text_len_r  <= text_len_nxt;
      str_cnt_r   <= str_cnt_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    status_r <= status_nxt; len_r <= len_nxt;   pass_r <= pass_nxt;
    zeros_r <= zeros_nxt;   sp_r <= sp_nxt;     dp_r <= dp_nxt;
    pre_r <= pre_nxt;       gap_r <= gap_nxt;   stop_r <= stop_nxt;
    e_pos_r <= e_pos_nxt;   acc_r <= acc_nxt;   n_r <= n_nxt;
    n0_r <= n0_nxt;         m_r <= m_nxt;       k_r <= k_nxt;
    off_r <= off_nxt;       e_str_r <= e_str_nxt; c_r <= c_nxt;
    hold_r <= hold_nxt;     idx_r <= idx_nxt;   cond_r <= cond_nxt;
    tail_r <= tail_nxt;
  end

endmodule
